FILE: hw/rtl/maoc_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// maoc_pkg
// Shared constants, microcode types and the control program of the moving
// average filter with outlier clamp.
// ============================================================================
package maoc_pkg;

    localparam int RING_DEPTH_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int WLEN_W     = 7;
    localparam int LIMIT_W    = 15;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUTLIER_ENABLE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OUTLIER_LIMIT  = 2'd2;

    localparam logic [WLEN_W-1:0]  WLEN_RESET   = 7'd16;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 15'd0;
    localparam int                 MIN_HELD     = 3;

    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    localparam int PC_W = 4;

    typedef enum logic [3:0] {
        UOP_NOP,
        UOP_FETCH,
        UOP_CLEAR,
        UOP_DIV,
        UOP_CLAMP,
        UOP_READ,
        UOP_UPDATE,
        UOP_AVG,
        UOP_SEND
    } uop_t;

    typedef enum logic [2:0] {
        C_NEXT,
        C_ALWAYS,
        C_NO_ITEM,
        C_PUSH,
        C_NO_CLAMP,
        C_DIV_BUSY,
        C_OUT_BUSY
    } cond_t;

    typedef struct packed {
        uop_t             uop;
        cond_t            cond;
        logic [PC_W-1:0]  target;
    } ucode_t;

    localparam logic [PC_W-1:0] L_FETCH     = 4'd0;
    localparam logic [PC_W-1:0] L_DISPATCH  = 4'd1;
    localparam logic [PC_W-1:0] L_CLEAR     = 4'd2;
    localparam logic [PC_W-1:0] L_CHECK     = 4'd3;
    localparam logic [PC_W-1:0] L_CDIV      = 4'd4;
    localparam logic [PC_W-1:0] L_CWAIT     = 4'd5;
    localparam logic [PC_W-1:0] L_CLAMP     = 4'd6;
    localparam logic [PC_W-1:0] L_READ      = 4'd7;
    localparam logic [PC_W-1:0] L_UPDATE    = 4'd8;
    localparam logic [PC_W-1:0] L_ADIV      = 4'd9;
    localparam logic [PC_W-1:0] L_AWAIT     = 4'd10;
    localparam logic [PC_W-1:0] L_AVG       = 4'd11;
    localparam logic [PC_W-1:0] L_HOLD      = 4'd12;
    localparam logic [PC_W-1:0] L_SEND      = 4'd13;

    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t w;
        unique case (pc)
            L_FETCH:    w = '{UOP_FETCH,  C_NO_ITEM,  L_FETCH};
            L_DISPATCH: w = '{UOP_NOP,    C_PUSH,     L_CHECK};
            L_CLEAR:    w = '{UOP_CLEAR,  C_ALWAYS,   L_HOLD};
            L_CHECK:    w = '{UOP_NOP,    C_NO_CLAMP, L_READ};
            L_CDIV:     w = '{UOP_DIV,    C_NEXT,     L_FETCH};
            L_CWAIT:    w = '{UOP_NOP,    C_DIV_BUSY, L_CWAIT};
            L_CLAMP:    w = '{UOP_CLAMP,  C_NEXT,     L_FETCH};
            L_READ:     w = '{UOP_READ,   C_NEXT,     L_FETCH};
            L_UPDATE:   w = '{UOP_UPDATE, C_NEXT,     L_FETCH};
            L_ADIV:     w = '{UOP_DIV,    C_NEXT,     L_FETCH};
            L_AWAIT:    w = '{UOP_NOP,    C_DIV_BUSY, L_AWAIT};
            L_AVG:      w = '{UOP_AVG,    C_NEXT,     L_FETCH};
            L_HOLD:     w = '{UOP_NOP,    C_OUT_BUSY, L_HOLD};
            L_SEND:     w = '{UOP_SEND,   C_ALWAYS,   L_FETCH};
            default:    w = '{UOP_NOP,    C_ALWAYS,   L_FETCH};
        endcase
        return w;
    endfunction

endpackage

FILE: hw/rtl/maoc_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// maoc_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ============================================================================
module maoc_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/maoc_div.sv
`timescale 1ns / 1ps
// ============================================================================
// maoc_div
// Iterative signed-by-unsigned divider, two quotient bits per cycle,
// quotient truncated toward zero.
// ============================================================================
module maoc_div #(
    parameter int DIVIDEND_W = 23,
    parameter int DIVISOR_W  = 7,
    parameter int QUOT_W     = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic signed [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]         divisor,
    output logic                         busy,
    output logic signed [QUOT_W-1:0]     quotient
);

    localparam int ITER  = (DIVIDEND_W + 1) / 2;
    localparam int SH_W  = 2 * ITER;
    localparam int CNT_W = $clog2(ITER + 1);

    logic                 busy_reg, busy_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [SH_W-1:0]      sh_reg, sh_next;
    logic [DIVISOR_W-1:0] rem_reg, rem_next;
    logic [DIVISOR_W-1:0] dsr_reg, dsr_next;
    logic                 neg_reg, neg_next;
    logic [DIVIDEND_W-1:0] mag;
    logic [DIVISOR_W:0]   trial;
    logic [QUOT_W:0]      q_mag;

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        sh_next   = sh_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        neg_next  = neg_reg;
        trial     = '0;
        mag       = dividend[DIVIDEND_W-1] ? DIVIDEND_W'(-dividend) : DIVIDEND_W'(dividend);
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(ITER);
            sh_next   = SH_W'(mag);
            rem_next  = '0;
            dsr_next  = divisor;
            neg_next  = dividend[DIVIDEND_W-1];
        end else if (busy_reg) begin
            for (int k = 0; k < 2; k++) begin
                trial   = {rem_next, sh_next[SH_W-1]};
                sh_next = {sh_next[SH_W-2:0], 1'b0};
                if (trial >= {1'b0, dsr_reg}) begin
                    rem_next   = DIVISOR_W'(trial - {1'b0, dsr_reg});
                    sh_next[0] = 1'b1;
                end else begin
                    rem_next = trial[DIVISOR_W-1:0];
                end
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        sh_reg  <= sh_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        neg_reg <= neg_next;
    end

    assign q_mag    = neg_reg ? (QUOT_W + 1)'(-sh_reg[QUOT_W:0]) : sh_reg[QUOT_W:0];
    assign quotient = q_mag[QUOT_W-1:0];
    assign busy     = busy_reg;

endmodule

FILE: hw/rtl/moving_average_outlier_clamp_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// moving_average_outlier_clamp_unit
// Windowed moving average over signed fixed-point samples with optional
// clamping of outlying samples, run by a microcoded sequencer.
// ============================================================================
// One item is handled at a time. A push runs one extra pass of the
// two-bit-per-cycle divider, to find the mean that it clamps against, when
// clamping is active and at least three samples are held. Each average
// costs one pass of that divider, and the step program runs one control
// word per cycle. The next item is taken while the previous result waits
// on the output; a stalled output holds the sequencer only when a second
// result is ready. The sample ring is a RAM with a registered read and
// needs no clearing after reset. Writing window_length empties the filter.
module moving_average_outlier_clamp_unit #(
    parameter int RING_DEPTH  = maoc_pkg::RING_DEPTH_DEF,
    parameter int SAMPLE_BITS = maoc_pkg::SAMPLE_BITS_DEF,
    parameter int CNT_W       = $clog2(RING_DEPTH + 1)
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_op,
    input  logic signed [SAMPLE_BITS-1:0]     s_sample,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [SAMPLE_BITS-1:0]     m_average,
    output logic [CNT_W-1:0]                  m_fill_count,
    output logic                              m_primed,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [maoc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [maoc_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int SUM_W = SAMPLE_BITS + $clog2(RING_DEPTH) + 1;
    localparam int CMP_W = (CNT_W > maoc_pkg::WLEN_W) ? CNT_W : maoc_pkg::WLEN_W;
    localparam int CW    = ((SAMPLE_BITS > maoc_pkg::LIMIT_W + 1) ?
                            SAMPLE_BITS : maoc_pkg::LIMIT_W + 1) + 2;
    localparam logic signed [CW-1:0] S_MAX =
        {{(CW - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic signed [CW-1:0] S_MIN =
        {{(CW - SAMPLE_BITS + 1){1'b1}}, {(SAMPLE_BITS - 1){1'b0}}};

    maoc_pkg::ucode_t                  uw;
    logic [maoc_pkg::PC_W-1:0]         pc_reg, pc_next;
    logic                              jump;

    logic [maoc_pkg::WLEN_W-1:0]       wlen_reg, wlen_next;
    logic                              en_reg, en_next;
    logic [maoc_pkg::LIMIT_W-1:0]      lim_reg, lim_next;

    logic signed [SUM_W-1:0]           sum_reg, sum_next;
    logic [CNT_W-1:0]                  held_reg, held_next;
    logic [PTR_W-1:0]                  wp_reg, wp_next;
    logic                              op_reg, op_next;
    logic signed [SAMPLE_BITS-1:0]     smp_reg, smp_next;
    logic signed [SAMPLE_BITS-1:0]     avg_reg, avg_next;

    logic                              mv_reg, mv_next;
    logic signed [SAMPLE_BITS-1:0]     mavg_reg, mavg_next;
    logic [CNT_W-1:0]                  mcnt_reg, mcnt_next;
    logic                              mpri_reg, mpri_next;

    logic [CNT_W-1:0]                  win;
    logic [CNT_W-1:0]                  wp_inc;
    logic                              full;
    logic                              cfg_fire;
    logic                              out_busy;

    logic                              div_start;
    logic                              div_busy;
    logic signed [SAMPLE_BITS-1:0]     div_q;

    logic                              ram_we;
    logic signed [SAMPLE_BITS-1:0]     ram_rdata;

    logic signed [CW-1:0]              s_x, a_x, l_x, d_x, ad_x, pick_x;

    assign uw        = maoc_pkg::ucode_rom(pc_reg);
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign s_ready   = (uw.uop == maoc_pkg::UOP_FETCH);
    assign out_busy  = mv_reg && !m_ready;
    assign div_start = (uw.uop == maoc_pkg::UOP_DIV);
    assign ram_we    = (uw.uop == maoc_pkg::UOP_UPDATE);
    assign full      = (held_reg >= win);
    assign wp_inc    = CNT_W'(wp_reg) + CNT_W'(1);

    always_comb begin
        if (wlen_reg == '0) begin
            win = CNT_W'(1);
        end else if (CMP_W'(wlen_reg) > CMP_W'(RING_DEPTH)) begin
            win = CNT_W'(RING_DEPTH);
        end else begin
            win = CNT_W'(wlen_reg);
        end
    end

    always_comb begin
        unique case (uw.cond)
            maoc_pkg::C_NEXT:     jump = 1'b0;
            maoc_pkg::C_ALWAYS:   jump = 1'b1;
            maoc_pkg::C_NO_ITEM:  jump = !s_valid;
            maoc_pkg::C_PUSH:     jump = (op_reg == maoc_pkg::OP_PUSH);
            maoc_pkg::C_NO_CLAMP: jump = !en_reg || (held_reg < CNT_W'(maoc_pkg::MIN_HELD));
            maoc_pkg::C_DIV_BUSY: jump = div_busy;
            maoc_pkg::C_OUT_BUSY: jump = out_busy;
            default:              jump = 1'b1;
        endcase
        pc_next = jump ? uw.target : pc_reg + maoc_pkg::PC_W'(1);
    end

    // Clamp the sample to the average plus or minus the limit.
    always_comb begin
        s_x    = CW'(smp_reg);
        a_x    = CW'(div_q);
        l_x    = CW'($signed({1'b0, lim_reg}));
        d_x    = s_x - a_x;
        ad_x   = d_x[CW-1] ? -d_x : d_x;
        pick_x = s_x;
        if (ad_x > l_x) begin
            pick_x = (s_x > a_x) ? a_x + l_x : a_x - l_x;
            if (pick_x > S_MAX) begin
                pick_x = S_MAX;
            end else if (pick_x < S_MIN) begin
                pick_x = S_MIN;
            end
        end
    end

    always_comb begin
        wlen_next = wlen_reg;
        en_next   = en_reg;
        lim_next  = lim_reg;
        sum_next  = sum_reg;
        held_next = held_reg;
        wp_next   = wp_reg;
        op_next   = op_reg;
        smp_next  = smp_reg;
        avg_next  = avg_reg;
        mv_next   = mv_reg && !m_ready;
        mavg_next = mavg_reg;
        mcnt_next = mcnt_reg;
        mpri_next = mpri_reg;

        unique case (uw.uop)
            maoc_pkg::UOP_FETCH: begin
                if (s_valid) begin
                    op_next  = s_op;
                    smp_next = s_sample;
                end
            end
            maoc_pkg::UOP_CLEAR: begin
                sum_next  = '0;
                held_next = '0;
                wp_next   = '0;
                avg_next  = '0;
            end
            maoc_pkg::UOP_CLAMP: begin
                smp_next = pick_x[SAMPLE_BITS-1:0];
            end
            maoc_pkg::UOP_UPDATE: begin
                if (full) begin
                    sum_next = sum_reg - SUM_W'(ram_rdata) + SUM_W'(smp_reg);
                end else begin
                    sum_next  = sum_reg + SUM_W'(smp_reg);
                    held_next = held_reg + CNT_W'(1);
                end
                wp_next = (wp_inc == win) ? '0 : wp_inc[PTR_W-1:0];
            end
            maoc_pkg::UOP_AVG: begin
                avg_next = div_q;
            end
            maoc_pkg::UOP_SEND: begin
                mv_next   = 1'b1;
                mavg_next = avg_reg;
                mcnt_next = held_reg;
                mpri_next = full;
            end
            default: begin
            end
        endcase

        if (cfg_fire) begin
            unique case (cfg_index)
                maoc_pkg::REG_WINDOW_LENGTH: begin
                    wlen_next = cfg_data[maoc_pkg::WLEN_W-1:0];
                    sum_next  = '0;
                    held_next = '0;
                    wp_next   = '0;
                end
                maoc_pkg::REG_OUTLIER_ENABLE: en_next  = cfg_data[0];
                maoc_pkg::REG_OUTLIER_LIMIT:  lim_next = cfg_data[maoc_pkg::LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg   <= maoc_pkg::L_FETCH;
            wlen_reg <= maoc_pkg::WLEN_RESET;
            en_reg   <= 1'b0;
            lim_reg  <= maoc_pkg::LIMIT_RESET;
            sum_reg  <= '0;
            held_reg <= '0;
            wp_reg   <= '0;
            mv_reg   <= 1'b0;
        end else begin
            pc_reg   <= pc_next;
            wlen_reg <= wlen_next;
            en_reg   <= en_next;
            lim_reg  <= lim_next;
            sum_reg  <= sum_next;
            held_reg <= held_next;
            wp_reg   <= wp_next;
            mv_reg   <= mv_next;
        end
        op_reg   <= op_next;
        smp_reg  <= smp_next;
        avg_reg  <= avg_next;
        mavg_reg <= mavg_next;
        mcnt_reg <= mcnt_next;
        mpri_reg <= mpri_next;
    end

    maoc_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (CNT_W),
        .QUOT_W     (SAMPLE_BITS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (held_reg),
        .busy     (div_busy),
        .quotient (div_q)
    );

    maoc_ram #(
        .WIDTH  (SAMPLE_BITS),
        .DEPTH  (RING_DEPTH),
        .ADDR_W (PTR_W)
    ) u_ring (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata (smp_reg),
        .raddr (wp_reg),
        .rdata (ram_rdata)
    );

    assign m_valid      = mv_reg;
    assign m_average    = mavg_reg;
    assign m_fill_count = mcnt_reg;
    assign m_primed     = mpri_reg;

endmodule

FILE: sim/moving_average_outlier_clamp_unit_test.sv
`timescale 1ns / 1ps
// ============================================================================
// moving_average_outlier_clamp_unit_test
// Self-checking bench for the moving average filter with outlier clamp. A
// short table of directed items and register writes runs first, followed by
// random phases that change the window, the clamp enable and the clamp limit
// between bursts of samples. Every accepted item is run through a local copy
// of the filter, and each result is checked field by field in order, with
// random gaps on the input side and random stalls on the output side.
// ============================================================================
module moving_average_outlier_clamp_unit_test;

    localparam int CFG_IDX_W  = maoc_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = maoc_pkg::CFG_DATA_W;
    localparam int WLEN_W     = maoc_pkg::WLEN_W;
    localparam int LIMIT_W    = maoc_pkg::LIMIT_W;
    localparam int MIN_HELD   = maoc_pkg::MIN_HELD;
    localparam logic OP_PUSH  = maoc_pkg::OP_PUSH;
    localparam logic OP_CLEAR = maoc_pkg::OP_CLEAR;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH  = maoc_pkg::REG_WINDOW_LENGTH;
    localparam logic [CFG_IDX_W-1:0] REG_OUTLIER_ENABLE = maoc_pkg::REG_OUTLIER_ENABLE;
    localparam logic [CFG_IDX_W-1:0] REG_OUTLIER_LIMIT  = maoc_pkg::REG_OUTLIER_LIMIT;
    localparam logic [WLEN_W-1:0]    WLEN_RESET         = maoc_pkg::WLEN_RESET;
    localparam logic [LIMIT_W-1:0]   LIMIT_RESET        = maoc_pkg::LIMIT_RESET;

    localparam int DEPTH         = maoc_pkg::RING_DEPTH_DEF;
    localparam int SBITS         = maoc_pkg::SAMPLE_BITS_DEF;
    localparam int CNT_W         = $clog2(DEPTH + 1);
    localparam int SMAX          = (1 << (SBITS - 1)) - 1;
    localparam int SMIN          = -(1 << (SBITS - 1));
    localparam int RESET_CYCLES  = 7;
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS   = 170;
    localparam int DRAIN_CYCLES  = 60;
    localparam int DIRECTED_ROWS = 33;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic signed [SBITS-1:0] average;
        logic [CNT_W-1:0]        fill_count;
        logic                    primed;
    } filter_result_t;

    typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_t;

    typedef struct {
        row_kind_t               kind;
        logic                    op;
        logic signed [SBITS-1:0] sample;
        logic [CFG_IDX_W-1:0]    reg_index;
        logic [CFG_DATA_W-1:0]   reg_data;
        bit                      known;
        filter_result_t          want;
    } stim_row_t;

    localparam filter_result_t NO_CHECK = '0;

    logic                     aclk = 1'b0;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    logic                     s_op;
    logic signed [SBITS-1:0]  s_sample;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic signed [SBITS-1:0]  m_average;
    logic [CNT_W-1:0]         m_fill_count;
    logic                     m_primed;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [CFG_DATA_W-1:0]    cfg_data;

    logic signed [SBITS-1:0]  hist_ring [DEPTH];
    int                       hist_ptr;
    int                       hist_count;
    int                       hist_sum;
    logic [WLEN_W-1:0]        cfg_wlen;
    logic                     cfg_clamp_en;
    logic [LIMIT_W-1:0]       cfg_limit;

    filter_result_t           pending_results [$];
    int                       mismatch_count = 0;
    bit                       in_idle_on = 1'b0;
    bit                       out_idle_on = 1'b0;
    int                       ready_hold = 0;

    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{ROW_ITEM,  OP_PUSH,  16'sh7FFF, REG_UNUSED, 15'd0, 1'b1, '{16'sd32767, 7'd1, 1'b0}},
        '{ROW_ITEM,  OP_PUSH,  16'sh8000, REG_UNUSED, 15'd0, 1'b1, '{16'sd0, 7'd2, 1'b0}},
        '{ROW_ITEM,  OP_CLEAR, 16'sh5A5A, REG_UNUSED, 15'd0, 1'b1, '{16'sd0, 7'd0, 1'b0}},
        '{ROW_ITEM,  OP_PUSH,  16'sh8000, REG_UNUSED, 15'd0, 1'b1, '{16'sh8000, 7'd1, 1'b0}},
        '{ROW_ITEM,  OP_PUSH,  16'shFFFF, REG_UNUSED, 15'd0, 1'b1, '{-16'sd16384, 7'd2, 1'b0}},
        '{ROW_ITEM,  OP_CLEAR, 16'shA5A5, REG_UNUSED, 15'd0, 1'b1, '{16'sd0, 7'd0, 1'b0}},
        '{ROW_WRITE, OP_PUSH,  16'sd0, REG_WINDOW_LENGTH, 15'd1, 1'b0, NO_CHECK},
        '{ROW_ITEM,  OP_PUSH,  16'sd100, REG_UNUSED, 15'd0, 1'b1, '{16'sd100, 7'd1, 1'b1}},
        '{ROW_ITEM,  OP_PUSH,  -16'sd5, REG_UNUSED, 15'd0, 1'b1, '{-16'sd5, 7'd1, 1'b1}},
        '{ROW_WRITE, OP_PUSH,  16'sd0, REG_WINDOW_LENGTH, 15'h7F80, 1'b0, NO_CHECK},
        '{ROW_ITEM,  OP_PUSH,  16'sd7, REG_UNUSED, 15'd0, 1'b1, '{16'sd7, 7'd1, 1'b1}},
        '{ROW_WRITE, OP_PUSH,  16'sd0, REG_WINDOW_LENGTH, 15'd127, 1'b0, NO_CHECK},
        '{ROW_WRITE, OP_PUSH,  16'sd0, REG_OUTLIER_ENABLE, 15'd1, 1'b0, NO_CHECK},
        '{ROW_WRITE, OP_PUSH,  16'sd0, REG_OUTLIER_LIMIT, 15'd0, 1'b0, NO_CHECK},
        '{ROW_ITEM,  OP_PUSH,  16'sd256, REG_UNUSED, 15'd0, 1'b1, '{16'sd256, 7'd1, 1'b0}},
        '{ROW_ITEM,  OP_PUSH,  16'sd512, REG_UNUSED, 15'd0, 1'b1, '{16'sd384, 7'd2, 1'b0}},
        '{ROW_ITEM,  OP_PUSH,  16'sd768, REG_UNUSED, 15'd0, 1'b1, '{16'sd512, 7'd3, 1'b0}},
        '{ROW_ITEM,  OP_PUSH,  16'sh7FFF, REG_UNUSED, 15'd0, 1'b1, '{16'sd512, 7'd4, 1'b0}},
        '{ROW_ITEM,  OP_PUSH,  16'sd512, REG_UNUSED, 15'd0, 1'b1, '{16'sd512, 7'd5, 1'b0}},
        '{ROW_ITEM,  OP_PUSH,  16'sh8000, REG_UNUSED, 15'd0, 1'b1, '{16'sd512, 7'd6, 1'b0}},
        '{ROW_WRITE, OP_PUSH,  16'sd0, REG_OUTLIER_LIMIT, 15'h7FFF, 1'b0, NO_CHECK},
        '{ROW_ITEM,  OP_PUSH,  16'sh8000, REG_UNUSED, 15'd0, 1'b0, NO_CHECK},
        '{ROW_ITEM,  OP_PUSH,  16'sh7FFF, REG_UNUSED, 15'd0, 1'b0, NO_CHECK},
        '{ROW_WRITE, OP_PUSH,  16'sd0, REG_OUTLIER_LIMIT, 15'd256, 1'b0, NO_CHECK},
        '{ROW_ITEM,  OP_PUSH,  16'sh1234, REG_UNUSED, 15'd0, 1'b0, NO_CHECK},
        '{ROW_WRITE, OP_PUSH,  16'sd0, REG_OUTLIER_ENABLE, 15'h7FFE, 1'b0, NO_CHECK},
        '{ROW_WRITE, OP_PUSH,  16'sd0, REG_UNUSED, 15'h2AAA, 1'b0, NO_CHECK},
        '{ROW_WRITE, OP_PUSH,  16'sd0, REG_WINDOW_LENGTH, 15'd3, 1'b0, NO_CHECK},
        '{ROW_ITEM,  OP_PUSH,  16'sd1, REG_UNUSED, 15'd0, 1'b0, NO_CHECK},
        '{ROW_ITEM,  OP_PUSH,  16'sd2, REG_UNUSED, 15'd0, 1'b0, NO_CHECK},
        '{ROW_ITEM,  OP_PUSH,  16'sd3, REG_UNUSED, 15'd0, 1'b0, NO_CHECK},
        '{ROW_ITEM,  OP_PUSH,  16'sd4, REG_UNUSED, 15'd0, 1'b0, NO_CHECK},
        '{ROW_ITEM,  OP_CLEAR, 16'sh7E81, REG_UNUSED, 15'd0, 1'b0, NO_CHECK}
    };

    moving_average_outlier_clamp_unit uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_sample     (s_sample),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_average    (m_average),
        .m_fill_count (m_fill_count),
        .m_primed     (m_primed),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int window_in_use();
        if (cfg_wlen == 0) return 1;
        if (cfg_wlen > DEPTH) return DEPTH;
        return int'(cfg_wlen);
    endfunction

    function automatic int held_mean();
        if (hist_count == 0) return 0;
        return hist_sum / hist_count;
    endfunction

    function automatic void empty_history();
        hist_ptr = 0;
        hist_count = 0;
        hist_sum = 0;
    endfunction

    function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_WINDOW_LENGTH: begin
                cfg_wlen = data[WLEN_W-1:0];
                empty_history();
            end
            REG_OUTLIER_ENABLE: cfg_clamp_en = data[0];
            REG_OUTLIER_LIMIT:  cfg_limit = data[LIMIT_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic filter_result_t step_average(input logic op,
                                                    input logic signed [SBITS-1:0] sample);
        int win;
        int s;
        int mean;
        int gap_to_mean;
        filter_result_t r;
        win = window_in_use();
        if (op == OP_CLEAR) begin
            empty_history();
        end else begin
            s = sample;
            if (cfg_clamp_en && hist_count >= MIN_HELD) begin
                mean = held_mean();
                gap_to_mean = (s > mean) ? s - mean : mean - s;
                if (gap_to_mean > int'(cfg_limit)) begin
                    s = (s > mean) ? mean + int'(cfg_limit) : mean - int'(cfg_limit);
                    if (s > SMAX) s = SMAX;
                    if (s < SMIN) s = SMIN;
                end
            end
            if (hist_count < win) begin
                hist_sum += s;
                hist_count++;
            end else begin
                hist_sum = hist_sum - hist_ring[hist_ptr] + s;
            end
            hist_ring[hist_ptr] = s[SBITS-1:0];
            hist_ptr++;
            if (hist_ptr >= win) hist_ptr = 0;
        end
        r.average = SBITS'(held_mean());
        r.fill_count = CNT_W'(hist_count);
        r.primed = (hist_count >= win);
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 20);
        return $urandom_range(30, 120);
    endfunction

    function automatic logic signed [SBITS-1:0] random_sample(input int centre, input int spread);
        int r;
        int v;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            v = $urandom;
        end else if (r < 14) begin
            case ($urandom_range(0, 3))
                0: v = SMAX;
                1: v = SMIN;
                2: v = 0;
                default: v = -1;
            endcase
        end else begin
            v = centre + int'($urandom_range(0, 2 * spread)) - spread;
            if (v > SMAX) v = SMAX;
            if (v < SMIN) v = SMIN;
        end
        return v[SBITS-1:0];
    endfunction

    task automatic send_item(input logic op, input logic signed [SBITS-1:0] sample,
                             input bit known, input filter_result_t want);
        int gap;
        filter_result_t predicted;
        gap = in_idle_on ? pick_gap() : 0;
        repeat (gap) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_op <= op;
        s_sample <= sample;
        do @(posedge aclk); while (!(s_valid && s_ready));
        predicted = step_average(op, sample);
        pending_results.push_back(known ? want : predicted);
    endtask

    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        apply_register(idx, data);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    always @(negedge aclk) begin
        if (!out_idle_on) begin
            m_ready <= 1'b1;
            ready_hold = 0;
        end else if (ready_hold > 0) begin
            ready_hold--;
        end else if ($urandom_range(0, 2) != 0) begin
            m_ready <= 1'b1;
            ready_hold = $urandom_range(0, 10);
        end else begin
            m_ready <= 1'b0;
            ready_hold = pick_gap();
        end
    end

    always @(posedge aclk) begin
        filter_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected item: average %0d fill_count %0d primed %0d",
                       m_average, m_fill_count, m_primed);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_average !== want.average) begin
                    $error("average: expected %0d, got %0d", want.average, m_average);
                    mismatch_count++;
                end
                if (m_fill_count !== want.fill_count) begin
                    $error("fill_count: expected %0d, got %0d", want.fill_count, m_fill_count);
                    mismatch_count++;
                end
                if (m_primed !== want.primed) begin
                    $error("primed: expected %0d, got %0d", want.primed, m_primed);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("moving_average_outlier_clamp_unit test failed");
        $finish;
    end

    initial begin
        int phase;
        int n;
        int wlen;
        int centre;
        int spread;
        logic [CFG_DATA_W-1:0] reg_word;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_op = OP_PUSH;
        s_sample = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_WINDOW_LENGTH;
        cfg_data = '0;
        cfg_wlen = WLEN_RESET;
        cfg_clamp_en = 1'b0;
        cfg_limit = LIMIT_RESET;
        foreach (hist_ring[i]) hist_ring[i] = '0;
        empty_history();
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        in_idle_on = 1'b1;
        out_idle_on = 1'b1;
        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_WRITE) begin
                settle();
                write_register(directed_rows[i].reg_index, directed_rows[i].reg_data);
            end else begin
                send_item(directed_rows[i].op, directed_rows[i].sample,
                          directed_rows[i].known, directed_rows[i].want);
            end
        end

        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            settle();
            if (phase == 0 || $urandom_range(0, 2) != 0) begin
                case ($urandom_range(0, 7))
                    0: wlen = 1;
                    1: wlen = 2;
                    2: wlen = 3;
                    3: wlen = DEPTH;
                    4: wlen = 0;
                    5: wlen = $urandom_range(DEPTH + 1, 127);
                    default: wlen = $urandom_range(4, 20);
                endcase
                reg_word = CFG_DATA_W'($urandom);
                reg_word[WLEN_W-1:0] = WLEN_W'(wlen);
                write_register(REG_WINDOW_LENGTH, reg_word);
            end
            reg_word = CFG_DATA_W'($urandom);
            reg_word[0] = ($urandom_range(0, 3) != 0);
            write_register(REG_OUTLIER_ENABLE, reg_word);
            case ($urandom_range(0, 4))
                0: reg_word = '0;
                1: reg_word = 15'h7FFF;
                2: reg_word = CFG_DATA_W'($urandom);
                default: reg_word = CFG_DATA_W'($urandom_range(0, 2047));
            endcase
            write_register(REG_OUTLIER_LIMIT, reg_word);

            centre = int'($urandom_range(0, 60000)) - 30000;
            spread = ($urandom_range(0, 1) != 0) ? 256 : 4096;
            in_idle_on = (phase != 1) && ($urandom_range(0, 3) != 0);
            out_idle_on = (phase != 1) && ($urandom_range(0, 3) != 0);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                send_item(($urandom_range(0, 49) == 0) ? OP_CLEAR : OP_PUSH,
                          random_sample(centre, spread), 1'b0, NO_CHECK);
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("moving_average_outlier_clamp_unit test passed");
        end else begin
            $display("moving_average_outlier_clamp_unit test failed");
        end
        $finish;
    end

endmodule
